// ----- design/orthorhombic_minimum_image_assert.svh -----
// Assertion macros shared by the checker of the periodic-box geometry unit.
// Every macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ORTHORHOMBIC_MINIMUM_IMAGE_ASSERT_SVH
`define ORTHORHOMBIC_MINIMUM_IMAGE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OMI_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OMI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after reset was sampled active.
`define OMI_ASSERT_RESET(name, cons, msg) \
  name: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

// ----- design/omi_pkg.sv -----
// Shared types and constants of the periodic-box geometry unit.
// No dependencies; every design module imports this package.
package omi_pkg;

  localparam int COORD_BITS    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int BOX_W         = 31;
  localparam int RECIP_W       = 32;
  localparam int NUM_AXES      = 3;
  localparam int CMD_W         = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_STAGES    = 7;

  localparam logic [BOX_W-1:0]    BOX_RST      = BOX_W'(32'h0001_0000);
  localparam logic [RECIP_W-1:0]  RECIP_RST    = '1;
  localparam logic [NUM_AXES-1:0] PERIODIC_RST = '1;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Command codes; the unused code behaves as the outside test.
  localparam logic [CMD_W-1:0] CMD_WRAP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DIST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X    = 3'd0,
    CFG_BOX_Y    = 3'd1,
    CFG_BOX_Z    = 3'd2,
    CFG_RECIP_X  = 3'd3,
    CFG_RECIP_Y  = 3'd4,
    CFG_RECIP_Z  = 3'd5,
    CFG_PERIODIC = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CMD_W-1:0]             cmd;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] res_x;
    logic signed [COORD_BITS-1:0] res_y;
    logic signed [COORD_BITS-1:0] res_z;
    logic                         outside;
    logic                         saturated;
  } out_t;

  // Load enables of the pipeline registers, from input register to output register.
  typedef struct packed {
    logic ld_in;
    logic ld_s2;
    logic ld_s3;
    logic ld_s4;
    logic ld_s5;
    logic ld_s6;
    logic ld_out;
  } pipe_en_t;

  // Per-axis findings handed from a lane to the merging stage.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] wrap_res;
    logic                         wrap_sat;
    logic signed [COORD_BITS-1:0] dist_res;
    logic                         dist_sat;
    logic                         outside;
  } lane_res_t;

endpackage

// ----- design/orthorhombic_minimum_image.sv -----
// Top level of the periodic-box geometry unit for a rectangular cell.
// Depends on omi_pkg, omi_ctrl, omi_lane and omi_merge.
//
// Usage: each transaction on the in_ channel carries a command and two points a and b.
// Wrap brings a back into the box, distance gives the minimum image of a minus b,
// and the test command only reports the outside flag. One transaction on the out_
// channel answers every input transaction, in order. Both channels use valid/ready.
// The cfg_ port writes box lengths, reciprocals and the periodic mask by register index,
// one register per cycle with cfg_we high; indexes past the list are ignored. Write
// configuration only while no transaction is in flight.
// Path: a result passes the input register, five lane stages and the output register.
// Throughput: one transaction per cycle while the receiver keeps out_ready high, set by
// the three axis lanes running side by side with registered multipliers, so a new
// input can enter every clock unless the receiver stalls.
// Reset: a synchronous active-low rst_n empties the pipeline and loads the default
// box (one unit per axis, all axes periodic). When the receiver stalls, the pipeline
// keeps accepting until its empty stages are filled, then drops in_ready.
module orthorhombic_minimum_image import omi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers; the user must change them only while the block is idle (the block
  // itself does not enforce it), as the lanes read them directly at every stage.
  logic [BOX_W-1:0]    box_len_r [NUM_AXES];
  logic [BOX_W-1:0]    box_len_nxt [NUM_AXES];
  logic [RECIP_W-1:0]  recip_r [NUM_AXES];
  logic [RECIP_W-1:0]  recip_nxt [NUM_AXES];
  logic [NUM_AXES-1:0] periodic_r;
  logic [NUM_AXES-1:0] periodic_nxt;

  always_comb begin
    box_len_nxt  = box_len_r;
    recip_nxt    = recip_r;
    periodic_nxt = periodic_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_BOX_X:    box_len_nxt[0] = cfg_wdata[BOX_W-1:0];
        CFG_BOX_Y:    box_len_nxt[1] = cfg_wdata[BOX_W-1:0];
        CFG_BOX_Z:    box_len_nxt[2] = cfg_wdata[BOX_W-1:0];
        CFG_RECIP_X:  recip_nxt[0]   = cfg_wdata[RECIP_W-1:0];
        CFG_RECIP_Y:  recip_nxt[1]   = cfg_wdata[RECIP_W-1:0];
        CFG_RECIP_Z:  recip_nxt[2]   = cfg_wdata[RECIP_W-1:0];
        CFG_PERIODIC: periodic_nxt   = cfg_wdata[NUM_AXES-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        box_len_r[i] <= BOX_RST;
        recip_r[i]   <= RECIP_RST;
      end
      periodic_r <= PERIODIC_RST;
    end else begin
      box_len_r  <= box_len_nxt;
      recip_r    <= recip_nxt;
      periodic_r <= periodic_nxt;
    end
  end

  // Handshake control and the command tag that follows each transaction.
  pipe_en_t         en;
  logic [CMD_W-1:0] merge_cmd;

  omi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_data.cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .merge_cmd (merge_cmd),
    .en        (en)
  );

  // Input register: the coordinates are spread into per-axis arrays for the lanes.
  logic signed [COORD_BITS-1:0] a_in [NUM_AXES];
  logic signed [COORD_BITS-1:0] b_in [NUM_AXES];
  logic signed [COORD_BITS-1:0] a1_r [NUM_AXES];
  logic signed [COORD_BITS-1:0] b1_r [NUM_AXES];

  always_comb begin
    a_in[0] = in_data.a_x;
    a_in[1] = in_data.a_y;
    a_in[2] = in_data.a_z;
    b_in[0] = in_data.b_x;
    b_in[1] = in_data.b_y;
    b_in[2] = in_data.b_z;
  end

  always_ff @(posedge clk) begin
    if (en.ld_in) begin
      a1_r <= a_in;
      b1_r <= b_in;
    end
  end

  // One lane per axis, all working on the same transaction in lockstep.
  lane_res_t lane_res [NUM_AXES];

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    omi_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .en       (en),
      .a        (a1_r[g]),
      .b        (b1_r[g]),
      .box_len  (box_len_r[g]),
      .recip    (recip_r[g]),
      .periodic (periodic_r[g]),
      .res      (lane_res[g])
    );
  end

  // The merging stage holds the output register that the receiver sees.
  omi_merge u_merge (
    .clk      (clk),
    .en       (en),
    .cmd      (merge_cmd),
    .lane_res (lane_res),
    .out_data (out_data)
  );

endmodule

// ----- design/omi_ctrl.sv -----
// Valid/ready control of the pipeline, with the command tag riding alongside.
// Depends on omi_pkg.
module omi_ctrl import omi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CMD_W-1:0] merge_cmd,
  output pipe_en_t         en
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] rdy;
  logic [CMD_W-1:0]      cmd_r   [NUM_STAGES-1];
  logic [CMD_W-1:0]      cmd_nxt [NUM_STAGES-1];

  // A stage may load when it is empty or its successor moves on.
  always_comb begin
    rdy[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (rdy[0]) begin
      valid_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_STAGES - 1; k++) begin
      cmd_nxt[k] = cmd_r[k];
    end
    if (rdy[0]) begin
      cmd_nxt[0] = in_cmd;
    end
    for (int k = 1; k < NUM_STAGES - 1; k++) begin
      if (rdy[k]) begin
        cmd_nxt[k] = cmd_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid_r[NUM_STAGES-1];
  assign merge_cmd = cmd_r[NUM_STAGES-2];

  assign en.ld_in  = rdy[0];
  assign en.ld_s2  = rdy[1];
  assign en.ld_s3  = rdy[2];
  assign en.ld_s4  = rdy[3];
  assign en.ld_s5  = rdy[4];
  assign en.ld_s6  = rdy[5];
  assign en.ld_out = rdy[6];

endmodule

// ----- design/omi_lane.sv -----
// One axis of the geometry unit: wrap and minimum-image datapath over five stages.
// Depends on omi_pkg; load enables come from omi_ctrl.
module omi_lane import omi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  pipe_en_t                     en,
  input  logic signed [COORD_BITS-1:0] a,
  input  logic signed [COORD_BITS-1:0] b,
  input  logic [BOX_W-1:0]             box_len,
  input  logic [RECIP_W-1:0]           recip,
  input  logic                         periodic,
  output lane_res_t                    res
);

  localparam int CB    = COORD_BITS;
  localparam int PW    = CB + RECIP_W;
  localparam int SH    = FRAC_BITS + RECIP_W;
  localparam int SUMW  = (PW + 1 > SH + 1) ? PW + 1 : SH + 1;
  localparam int NW    = (PW + 1 > SH) ? PW + 1 - SH : 1;
  localparam int NBW   = NW + BOX_W;
  localparam int LIM_W = (NBW > 63) ? NBW : 63;
  localparam int NBK   = (NBW < 63) ? NBW : 63;
  localparam int RW    = ((CB > NBK) ? CB : NBK) + 1;
  localparam int HW    = (CB + 1 > BOX_W) ? CB + 1 : BOX_W;
  localparam int DW    = (CB + 2 > BOX_W + 2) ? CB + 2 : BOX_W + 2;

  localparam logic [SUMW-1:0]  RND_BIAS = SUMW'(1) << (SH - 1);
  localparam logic [LIM_W-1:0] NB_LIMIT = LIM_W'(1) << 62;

  // Stage 2: magnitude, half-box test, raw difference.
  logic [CB-1:0]        mag;
  logic                 gt_half;
  logic signed [CB:0]   diff;
  logic [CB-1:0]        m2_r;
  logic                 neg2_r, wen2_r, out2_r;
  logic signed [CB:0]   d2_r;

  always_comb begin
    mag     = a[CB-1] ? ((~unsigned'(a)) + CB'(1)) : unsigned'(a);
    gt_half = HW'({mag, 1'b0}) > HW'(box_len);
    diff    = {a[CB-1], a} - {b[CB-1], b};
  end

  always_ff @(posedge clk) begin
    if (en.ld_s2) begin
      m2_r   <= mag;
      neg2_r <= a[CB-1];
      wen2_r <= periodic && gt_half;
      out2_r <= gt_half;
      d2_r   <= diff;
    end
  end

  // Stage 3: magnitude times reciprocal; one box length of correction on the difference.
  logic signed [DW-1:0] d_ext, two_d, box_s, d_adj;
  logic [PW-1:0]        prod_mr;
  logic [PW-1:0]        p3_r;
  logic [CB-1:0]        m3_r;
  logic                 neg3_r, wen3_r, out3_r;
  logic signed [DW-1:0] dadj3_r;

  always_comb begin
    d_ext   = DW'(d2_r);
    two_d   = d_ext <<< 1;
    box_s   = signed'(DW'(box_len));
    prod_mr = PW'(m2_r) * PW'(recip);
    if (periodic && (two_d > box_s)) begin
      d_adj = d_ext - box_s;
    end else if (periodic && (two_d < -box_s)) begin
      d_adj = d_ext + box_s;
    end else begin
      d_adj = d_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_s3) begin
      p3_r    <= prod_mr;
      m3_r    <= m2_r;
      neg3_r  <= neg2_r;
      wen3_r  <= wen2_r;
      out3_r  <= out2_r;
      dadj3_r <= d_adj;
    end
  end

  // Stage 4: round the box count half up; clip the difference.
  logic [SUMW-1:0]      rnd_sum;
  logic [NW-1:0]        n_cnt;
  logic signed [CB-1:0] d_clip;
  logic                 d_sat;
  logic [NW-1:0]        n4_r;
  logic [CB-1:0]        m4_r;
  logic                 neg4_r, wen4_r, out4_r;
  logic signed [CB-1:0] dres4_r;
  logic                 dsat4_r;

  always_comb begin
    rnd_sum = SUMW'(p3_r) + RND_BIAS;
    n_cnt   = NW'(rnd_sum >> SH);
    if (dadj3_r > DW'(COORD_MAX)) begin
      d_clip = COORD_MAX;
      d_sat  = 1'b1;
    end else if (dadj3_r < DW'(COORD_MIN)) begin
      d_clip = COORD_MIN;
      d_sat  = 1'b1;
    end else begin
      d_clip = dadj3_r[CB-1:0];
      d_sat  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_s4) begin
      n4_r    <= n_cnt;
      m4_r    <= m3_r;
      neg4_r  <= neg3_r;
      wen4_r  <= wen3_r;
      out4_r  <= out3_r;
      dres4_r <= d_clip;
      dsat4_r <= d_sat;
    end
  end

  // Stage 5: whole box lengths to remove, held at the limit when huge.
  logic [NBW-1:0]       prod_nb;
  logic [LIM_W-1:0]     prod_ext;
  logic [NBK-1:0]       nb;
  logic [NBK-1:0]       nb5_r;
  logic [CB-1:0]        m5_r;
  logic                 neg5_r, out5_r;
  logic signed [CB-1:0] dres5_r;
  logic                 dsat5_r;

  always_comb begin
    prod_nb  = NBW'(n4_r) * NBW'(box_len);
    prod_ext = LIM_W'(prod_nb);
    if (!wen4_r) begin
      nb = '0;
    end else if (prod_ext > NB_LIMIT) begin
      nb = NB_LIMIT[NBK-1:0];
    end else begin
      nb = prod_ext[NBK-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_s5) begin
      nb5_r   <= nb;
      m5_r    <= m4_r;
      neg5_r  <= neg4_r;
      out5_r  <= out4_r;
      dres5_r <= dres4_r;
      dsat5_r <= dsat4_r;
    end
  end

  // Stage 6: subtract, restore the sign, clip.
  logic signed [RW-1:0] r_mag, r_sgn;
  lane_res_t            res_nxt;
  lane_res_t            res_r;

  always_comb begin
    r_mag   = $signed(RW'(m5_r)) - $signed(RW'(nb5_r));
    r_sgn   = neg5_r ? -r_mag : r_mag;
    res_nxt = '0;
    if (r_sgn > RW'(COORD_MAX)) begin
      res_nxt.wrap_res = COORD_MAX;
      res_nxt.wrap_sat = 1'b1;
    end else if (r_sgn < RW'(COORD_MIN)) begin
      res_nxt.wrap_res = COORD_MIN;
      res_nxt.wrap_sat = 1'b1;
    end else begin
      res_nxt.wrap_res = r_sgn[CB-1:0];
      res_nxt.wrap_sat = 1'b0;
    end
    res_nxt.dist_res = dres5_r;
    res_nxt.dist_sat = dsat5_r;
    res_nxt.outside  = out5_r;
  end

  always_ff @(posedge clk) begin
    if (en.ld_s6) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ----- design/omi_merge.sv -----
// Merging stage: picks each lane's result by command and folds the flags.
// Depends on omi_pkg; holds the output register of the top level's result channel.
module omi_merge import omi_pkg::*; (
  input  logic             clk,
  input  pipe_en_t         en,
  input  logic [CMD_W-1:0] cmd,
  input  lane_res_t        lane_res [NUM_AXES],
  output out_t             out_data
);

  logic signed [COORD_BITS-1:0] comp [NUM_AXES];
  logic                         sat;
  logic                         outside;
  out_t                         out_nxt;
  out_t                         out_r;

  always_comb begin
    sat     = 1'b0;
    outside = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      outside = outside | lane_res[i].outside;
      case (cmd)
        CMD_WRAP: begin
          comp[i] = lane_res[i].wrap_res;
          sat     = sat | lane_res[i].wrap_sat;
        end
        CMD_DIST: begin
          comp[i] = lane_res[i].dist_res;
          sat     = sat | lane_res[i].dist_sat;
        end
        default: begin
          comp[i] = '0;
        end
      endcase
    end
    out_nxt.res_x     = comp[0];
    out_nxt.res_y     = comp[1];
    out_nxt.res_z     = comp[2];
    out_nxt.outside   = outside;
    out_nxt.saturated = sat;
  end

  always_ff @(posedge clk) begin
    if (en.ld_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ----- design/omi_checker.sv -----
// Port-level checks of the periodic-box geometry unit, bound to its top level.
// Depends on omi_pkg and orthorhombic_minimum_image_assert.svh.
`include "orthorhombic_minimum_image_assert.svh"

module omi_checker import omi_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // Reset empties the pipeline, so nothing is offered and input is open.
  `OMI_ASSERT_RESET(a_reset_empty, (!out_valid && in_ready), "pipeline not empty after reset")

  // Input backpressure can only come from a result held by the receiver.
  `OMI_ASSERT_SAME(a_ready_only_on_stall, !in_ready, (out_valid && !out_ready), "in_ready low without output stall")

  // A clipped result shows at least one component at the edge of the range.
  `OMI_ASSERT_SAME(a_sat_at_limit, (out_valid && out_data.saturated), (out_data.res_x == COORD_MAX || out_data.res_x == COORD_MIN || out_data.res_y == COORD_MAX || out_data.res_y == COORD_MIN || out_data.res_z == COORD_MAX || out_data.res_z == COORD_MIN), "saturated flag without clipped component")

  // A stalled result stays offered and unchanged.
  `OMI_ASSERT_NEXT(a_out_hold, (out_valid && !out_ready), (out_valid && $stable(out_data)), "stalled result changed")

endmodule

bind orthorhombic_minimum_image omi_checker u_omi_checker (.*);
